>>> hw/rtl/ipc_pkg.sv
// Shared types and constants for the injector and ignition pulse capture unit.
// Holds the request structs of both channels, the product stage struct and the
// configuration register indexes. Depends on nothing.
package ipc_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FUEL_RATE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_FUEL  = 2'd1;

    // Register values after reset: a rate of 1.0 in Q16.16 and no floor.
    localparam logic [31:0] FUEL_RATE_RESET = 32'h0001_0000;
    localparam logic [31:0] MIN_FUEL_RESET  = 32'h0000_0000;

    // Lines present on the sample request.
    localparam int LINE_BITS = 4;

    // One sample of the cylinder lines with its timestamp.
    typedef struct packed {
        logic [31:0]          now_us;
        logic [LINE_BITS-1:0] injector_lines;
        logic [LINE_BITS-1:0] ignition_lines;
    } ipc_in_t;

    // One event result for a single cylinder.
    typedef struct packed {
        logic [1:0]  cylinder;
        logic        injection_done;
        logic [31:0] pulse_width_us;
        logic [31:0] fuel_amount;
        logic        ignition_rose;
        logic        last_event;
    } ipc_out_t;

    // Event after the rate multiplication, before saturation and flooring.
    typedef struct packed {
        logic [1:0]  cylinder;
        logic        injection_done;
        logic        ignition_rose;
        logic        last_event;
        logic [31:0] pulse_width_us;
        logic [63:0] product;
    } ipc_prod_t;

endpackage

>>> hw/rtl/injector_ignition_pulse_capture_unit.sv
// Path: sample, event (held until all its events are taken), product and result registers.
// Throughput: samples without edges are taken one per cycle while no sample with events waits;
// the single rate multiplier serves one event a cycle while the product register is free.
// Reset: clears all line state, start times and pipeline valids; fuel_rate returns to 1.0
// (Q16.16) and min_fuel to zero.
module injector_ignition_pulse_capture_unit #(
    parameter int CYLINDERS = 4,
    parameter int TIME_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  ipc_pkg::ipc_in_t                     sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output ipc_pkg::ipc_out_t                    result,
    input  logic                                 cfg_write,
    input  logic [ipc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ipc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import ipc_pkg::*;

    logic [31:0] fuel_rate_reg;
    logic [31:0] min_fuel_reg;

    logic                       burst_valid;
    logic [CYLINDERS-1:0]       burst_pend;
    logic [CYLINDERS-1:0]       burst_done;
    logic [CYLINDERS-1:0]       burst_fired;
    logic [CYLINDERS-1:0][31:0] burst_width;
    logic [CYLINDERS-1:0]       pick;
    logic                       take;
    logic                       prod_valid;
    ipc_prod_t                  prod;
    logic                       prod_ready;

    // Configuration registers; writes to unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fuel_rate_reg <= FUEL_RATE_RESET;
            min_fuel_reg  <= MIN_FUEL_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_FUEL_RATE: fuel_rate_reg <= cfg_data;
                CFG_MIN_FUEL:  min_fuel_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Edge detection and event collection.
    ipc_capture #(
        .CYLINDERS(CYLINDERS),
        .TIME_BITS(TIME_BITS)
    ) u_capture (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .burst_valid  (burst_valid),
        .burst_pend   (burst_pend),
        .burst_done   (burst_done),
        .burst_fired  (burst_fired),
        .burst_width  (burst_width),
        .pick         (pick),
        .take         (take)
    );

    // One event per cycle through the rate multiplier while the product register can take it.
    ipc_serialize #(
        .CYLINDERS(CYLINDERS)
    ) u_serialize (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst_pend  (burst_pend),
        .burst_done  (burst_done),
        .burst_fired (burst_fired),
        .burst_width (burst_width),
        .fuel_rate   (fuel_rate_reg),
        .pick        (pick),
        .take        (take),
        .prod_valid  (prod_valid),
        .prod        (prod),
        .prod_ready  (prod_ready)
    );

    // Saturation, floor and result register.
    ipc_fuel u_fuel (
        .clk          (clk),
        .rst_n        (rst_n),
        .prod_valid   (prod_valid),
        .prod         (prod),
        .prod_ready   (prod_ready),
        .min_fuel     (min_fuel_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> hw/rtl/ipc_capture.sv
// Sample register, per-cylinder line state and edge detection.
// Collects the events of one sample into an event register for serialising.
// Depends on ipc_pkg.
module ipc_capture #(
    parameter int CYLINDERS = 4,
    parameter int TIME_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  ipc_pkg::ipc_in_t            sample,
    output logic                        burst_valid,
    output logic [CYLINDERS-1:0]        burst_pend,
    output logic [CYLINDERS-1:0]        burst_done,
    output logic [CYLINDERS-1:0]        burst_fired,
    output logic [CYLINDERS-1:0][31:0]  burst_width,
    input  logic [CYLINDERS-1:0]        pick,
    input  logic                        take
);
    import ipc_pkg::*;

    // Sample register.
    logic                 s1_valid_reg, s1_valid_next;
    ipc_in_t              s1_reg;

    // Line state per cylinder.
    logic [CYLINDERS-1:0]                 injecting_reg;
    logic [CYLINDERS-1:0]                 igniting_reg;
    logic [CYLINDERS-1:0][TIME_BITS-1:0]  start_reg;

    // Event register handed to the serialiser.
    logic                       burst_valid_reg, burst_valid_next;
    logic [CYLINDERS-1:0]       pend_reg, pend_next;
    logic [CYLINDERS-1:0]       done_reg;
    logic [CYLINDERS-1:0]       fired_reg;
    logic [CYLINDERS-1:0][31:0] width_reg;

    logic [TIME_BITS-1:0]                 now_t;
    logic [CYLINDERS-1:0]                 inj_on;
    logic [CYLINDERS-1:0]                 ign_on;
    logic [CYLINDERS-1:0]                 inj_rise;
    logic [CYLINDERS-1:0]                 inj_fall;
    logic [CYLINDERS-1:0]                 ign_rise;
    logic [CYLINDERS-1:0][TIME_BITS-1:0]  diff;
    logic [CYLINDERS-1:0][31:0]           width_sat;
    logic [CYLINDERS-1:0]                 event_mask;
    logic                                 any_event;
    logic [CYLINDERS-1:0]                 pend_left;
    logic                                 burst_free;
    logic                                 burst_load;
    logic                                 s1_go;
    logic                                 accept;

    // The timestamp is taken modulo the time base.
    assign now_t = TIME_BITS'(s1_reg.now_us);

    // Edge detection and width measurement, one slice per cylinder.
    for (genvar c = 0; c < CYLINDERS; c++) begin : g_cyl
        if (c < LINE_BITS) begin : g_line
            assign inj_on[c] = s1_reg.injector_lines[c];
            assign ign_on[c] = s1_reg.ignition_lines[c];
        end else begin : g_noline
            // Cylinders without a line bit always read as low.
            assign inj_on[c] = 1'b0;
            assign ign_on[c] = 1'b0;
        end

        assign inj_rise[c] = inj_on[c] && !injecting_reg[c];
        assign inj_fall[c] = !inj_on[c] && injecting_reg[c];
        assign ign_rise[c] = ign_on[c] && !igniting_reg[c];
        assign diff[c]     = now_t - start_reg[c];

        if (TIME_BITS > 32) begin : g_wide
            // A width that does not fit in 32 bits saturates.
            assign width_sat[c] = (|diff[c][TIME_BITS-1:32]) ? '1 : diff[c][31:0];
        end else begin : g_narrow
            assign width_sat[c] = 32'(diff[c]);
        end
    end

    assign event_mask = inj_fall | ign_rise;
    assign any_event  = |event_mask;

    // Handshake: a sample without events drains freely, one with events
    // waits until the event register is free.
    assign pend_left    = pend_reg & ~pick;
    assign burst_free   = !burst_valid_reg || (take && (pend_left == '0));
    assign s1_go        = s1_valid_reg && (!any_event || burst_free);
    assign burst_load   = s1_go && any_event;
    assign sample_stall = s1_valid_reg && !s1_go;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        burst_valid_next = burst_valid_reg;
        pend_next        = pend_reg;
        if (burst_load) begin
            burst_valid_next = 1'b1;
            pend_next        = event_mask;
        end else if (take) begin
            pend_next        = pend_left;
            burst_valid_next = (pend_left != '0);
        end
    end

    // Control registers and cylinder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg    <= 1'b0;
            burst_valid_reg <= 1'b0;
            pend_reg        <= '0;
            injecting_reg   <= '0;
            igniting_reg    <= '0;
            start_reg       <= '0;
        end else begin
            s1_valid_reg    <= s1_valid_next;
            burst_valid_reg <= burst_valid_next;
            pend_reg        <= pend_next;
            if (s1_go) begin
                injecting_reg <= inj_on;
                igniting_reg  <= ign_on;
                for (int i = 0; i < CYLINDERS; i++) begin
                    if (inj_rise[i]) begin
                        start_reg[i] <= now_t;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_reg <= sample;
        end
        if (burst_load) begin
            done_reg  <= inj_fall;
            fired_reg <= ign_rise;
            for (int i = 0; i < CYLINDERS; i++) begin
                width_reg[i] <= inj_fall[i] ? width_sat[i] : 32'd0;
            end
        end
    end

    assign burst_valid = burst_valid_reg;
    assign burst_pend  = pend_reg;
    assign burst_done  = done_reg;
    assign burst_fired = fired_reg;
    assign burst_width = width_reg;

endmodule

>>> hw/rtl/ipc_serialize.sv
// Event serialiser: picks the lowest pending cylinder each cycle and, when the product
// register is free or leaving, multiplies its pulse width by the fuel rate into that register.
// Depends on ipc_pkg.
module ipc_serialize #(
    parameter int CYLINDERS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        burst_valid,
    input  logic [CYLINDERS-1:0]        burst_pend,
    input  logic [CYLINDERS-1:0]        burst_done,
    input  logic [CYLINDERS-1:0]        burst_fired,
    input  logic [CYLINDERS-1:0][31:0]  burst_width,
    input  logic [31:0]                 fuel_rate,
    output logic [CYLINDERS-1:0]        pick,
    output logic                        take,
    output logic                        prod_valid,
    output ipc_pkg::ipc_prod_t          prod,
    input  logic                        prod_ready
);
    import ipc_pkg::*;

    localparam int SEL_BITS = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;

    logic          prod_valid_reg, prod_valid_next;
    ipc_prod_t     prod_reg;

    logic [SEL_BITS-1:0] sel_idx;
    logic [2:0]          sel_idx_wide;
    logic [31:0]         sel_width;
    logic                sel_done;
    logic                sel_fired;
    logic                sel_last;
    logic [63:0]         product;
    logic                prod_space;

    // Lowest pending cylinder, as a one-hot vector.
    assign pick = burst_pend & (~burst_pend + CYLINDERS'(1));

    // Encode the pick and select that cylinder's event.
    always_comb
    begin
        sel_idx   = '0;
        sel_width = '0;
        sel_done  = 1'b0;
        sel_fired = 1'b0;
        for (int i = 0; i < CYLINDERS; i++) begin
            if (pick[i]) begin
                sel_idx   = sel_idx | SEL_BITS'(i);
                sel_width = sel_width | burst_width[i];
                sel_done  = sel_done | burst_done[i];
                sel_fired = sel_fired | burst_fired[i];
            end
        end
    end

    assign sel_idx_wide = 3'(sel_idx);
    assign sel_last     = ((burst_pend & ~pick) == '0);
    assign product      = 64'(sel_width) * 64'(fuel_rate);

    // One event moves on whenever the product register is free or leaving.
    assign prod_space = !prod_valid_reg || prod_ready;
    assign take       = burst_valid && prod_space;

    always_comb
    begin
        prod_valid_next = prod_valid_reg;
        if (prod_space) begin
            prod_valid_next = burst_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            prod_reg.cylinder       <= sel_idx_wide[1:0];
            prod_reg.injection_done <= sel_done;
            prod_reg.ignition_rose  <= sel_fired;
            prod_reg.last_event     <= sel_last;
            prod_reg.pulse_width_us <= sel_width;
            prod_reg.product        <= product;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

>>> hw/rtl/ipc_fuel.sv
// Fuel stage and result register: scales the Q48.16 product, saturates it to
// 32 bits, applies the minimum, gives zero fuel without a finished pulse and holds the result
// for the downstream side. Depends on ipc_pkg.
module ipc_fuel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               prod_valid,
    input  ipc_pkg::ipc_prod_t prod,
    output logic               prod_ready,
    input  logic [31:0]        min_fuel,
    output logic               result_valid,
    input  logic               result_stall,
    output ipc_pkg::ipc_out_t  result
);
    import ipc_pkg::*;

    logic        out_valid_reg, out_valid_next;
    ipc_out_t    out_reg;

    logic [31:0] fuel_sat;
    logic [31:0] fuel_floor;
    logic [31:0] fuel;
    logic        load;

    // Drop the fraction, saturate, then raise to the floor.
    assign fuel_sat   = (|prod.product[63:48]) ? '1 : prod.product[47:16];
    assign fuel_floor = (fuel_sat < min_fuel) ? min_fuel : fuel_sat;
    assign fuel       = prod.injection_done ? fuel_floor : 32'd0;

    // The result register takes a new request when empty or being drained.
    assign prod_ready = !out_valid_reg || !result_stall;
    assign load       = prod_valid && prod_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (prod_ready) begin
            out_valid_next = prod_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg.cylinder       <= prod.cylinder;
            out_reg.injection_done <= prod.injection_done;
            out_reg.pulse_width_us <= prod.pulse_width_us;
            out_reg.fuel_amount    <= fuel;
            out_reg.ignition_rose  <= prod.ignition_rose;
            out_reg.last_event     <= prod.last_event;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> hw/rtl/ipc_checker.sv
// Port-level checker for the pulse capture unit, attached by the bind below.
// Watches only the result channel. Depends on ipc_pkg.
module ipc_checker #(
    parameter int CYLINDERS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              result_valid,
    input  logic              result_stall,
    input  ipc_pkg::ipc_out_t result
);
    import ipc_pkg::*;

    // A stalled request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result request changed");

    // Every result carries at least one event.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.injection_done || result.ignition_rose)
        else $error("result without an event");

    // Without a finished pulse the width and fuel read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.injection_done
            |-> result.pulse_width_us == 32'd0 && result.fuel_amount == 32'd0)
        else $error("width or fuel set without a finished pulse");

    // Results of one sample come in rising cylinder order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result.last_event) ##1 result_valid
            |-> CYLINDERS > 4 || result.cylinder > $past(result.cylinder))
        else $error("cylinder order broken within one sample");

    // The cylinder index stays within the configured count.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> CYLINDERS >= 4 || int'(result.cylinder) < CYLINDERS)
        else $error("cylinder index out of range");

endmodule

bind injector_ignition_pulse_capture_unit ipc_checker #(
    .CYLINDERS(CYLINDERS)
) u_ipc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
